@@ hw/rtl/lfr_pkg.sv @@
`default_nettype none

package lfr_pkg;

	localparam int CMD_W  = 2;
	localparam int FID_W  = 6;
	localparam int SIZE_W = 7;
	localparam int CAP_W  = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [CMD_W-1:0] {
		CMD_VICTIM = 2'd0,
		CMD_PIN    = 2'd1,
		CMD_UNPIN  = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [FID_W-1:0] frame;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [FID_W-1:0]  victim_frame;
		logic [SIZE_W-1:0] size;
	} res_t;

endpackage

`default_nettype wire

@@ hw/rtl/lfr_link_ram.sv @@
`default_nettype none

module lfr_link_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 6
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/lfr_seq.sv @@
`default_nettype none

module lfr_seq #(
	parameter int FRAMES = 64
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         req_valid,
	output logic                        req_ready,
	input  lfr_pkg::req_t               req,
	input  wire  [lfr_pkg::CAP_W-1:0]   cap,
	output logic                        res_valid,
	input  wire                         res_ready,
	output lfr_pkg::res_t               res
);

	localparam int IW = $clog2(FRAMES);
	// only frame ids that fit the id field can ever be present
	localparam int PD = (FRAMES < (1 << lfr_pkg::FID_W)) ? FRAMES : (1 << lfr_pkg::FID_W);
	localparam int PW = $clog2(PD);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_LINK   = 5'b00100,
		ST_PUSH   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t                     state_q, state_d;
	lfr_pkg::cmd_t              cmd_q;
	logic [lfr_pkg::FID_W-1:0]  fid_q;
	logic [IW-1:0]              tgt_q, tgt_d;
	logic                       push_q, push_d;
	logic                       found_q, found_d;
	logic [IW-1:0]              newest_q, oldest_q;
	logic [lfr_pkg::SIZE_W-1:0] count_q;
	logic [PD-1:0]              present_q;

	logic                       fid_ok;
	logic [IW-1:0]              fidx;
	logic                       fid_present;
	logic [lfr_pkg::CAP_W-1:0]  cap_eff;
	logic                       full;

	logic          nl_we, ol_we;
	logic [IW-1:0] nl_waddr, nl_wdata, ol_waddr, ol_wdata;
	logic [IW-1:0] nl_rdata, ol_rdata;

	assign fid_ok      = 32'(fid_q) < FRAMES;
	assign fidx        = IW'(fid_q);
	assign fid_present = fid_ok && present_q[fid_q[PW-1:0]];

	always_comb begin
		cap_eff = cap;
		if (cap == '0) begin
			cap_eff = lfr_pkg::CAP_W'(1);
		end else if (32'(cap) > FRAMES) begin
			cap_eff = lfr_pkg::CAP_W'(FRAMES);
		end
	end

	assign full = (count_q >= lfr_pkg::SIZE_W'(cap_eff)) && (count_q != '0);

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	assign res.found        = found_q;
	assign res.victim_frame = found_q ? lfr_pkg::FID_W'(tgt_q) : '0;
	assign res.size         = count_q;

	always_comb begin
		state_d = state_q;
		tgt_d   = tgt_q;
		push_d  = push_q;
		found_d = found_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				push_d  = 1'b0;
				found_d = 1'b0;
				state_d = ST_DONE;
				case (cmd_q)
					lfr_pkg::CMD_VICTIM: begin
						if (count_q != '0) begin
							tgt_d   = oldest_q;
							found_d = 1'b1;
							state_d = ST_LINK;
						end
					end
					lfr_pkg::CMD_PIN: begin
						if (fid_present) begin
							tgt_d   = fidx;
							state_d = ST_LINK;
						end
					end
					lfr_pkg::CMD_UNPIN: begin
						if (fid_ok && !fid_present) begin
							push_d = 1'b1;
							if (full) begin
								// drop the oldest frame before inserting
								tgt_d   = oldest_q;
								state_d = ST_LINK;
							end else begin
								state_d = ST_PUSH;
							end
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_LINK: begin
				state_d = push_q ? ST_PUSH : ST_DONE;
			end
			ST_PUSH: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// link writes: unlink splices the neighbours, push hooks onto the newest end
	always_comb begin
		nl_we    = 1'b0;
		nl_waddr = ol_rdata;
		nl_wdata = nl_rdata;
		ol_we    = 1'b0;
		ol_waddr = nl_rdata;
		ol_wdata = ol_rdata;
		if (state_q == ST_LINK) begin
			nl_we = (tgt_q != oldest_q);
			ol_we = (tgt_q != newest_q);
		end else if (state_q == ST_PUSH) begin
			nl_we    = (count_q != '0);
			nl_waddr = newest_q;
			nl_wdata = fidx;
			ol_we    = 1'b1;
			ol_waddr = fidx;
			ol_wdata = newest_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			push_q    <= 1'b0;
			found_q   <= 1'b0;
			newest_q  <= '0;
			oldest_q  <= '0;
			count_q   <= '0;
			present_q <= '0;
		end else begin
			state_q <= state_d;
			push_q  <= push_d;
			found_q <= found_d;
			if (state_q == ST_LINK) begin
				if (tgt_q == oldest_q) begin
					oldest_q <= nl_rdata;
				end
				if (tgt_q == newest_q) begin
					newest_q <= ol_rdata;
				end
				present_q[tgt_q[PW-1:0]] <= 1'b0;
				count_q <= count_q - lfr_pkg::SIZE_W'(1);
			end else if (state_q == ST_PUSH) begin
				if (count_q == '0) begin
					oldest_q <= fidx;
				end
				newest_q <= fidx;
				present_q[fid_q[PW-1:0]] <= 1'b1;
				count_q <= count_q + lfr_pkg::SIZE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		tgt_q <= tgt_d;
		if (req_valid && req_ready) begin
			cmd_q <= req.cmd;
			fid_q <= req.frame;
		end
	end

	lfr_link_ram #(
		.DEPTH(FRAMES),
		.WIDTH(IW)
	) u_newer_ram (
		.clk  (clk),
		.we   (nl_we),
		.waddr(nl_waddr),
		.wdata(nl_wdata),
		.raddr(tgt_d),
		.rdata(nl_rdata)
	);

	lfr_link_ram #(
		.DEPTH(FRAMES),
		.WIDTH(IW)
	) u_older_ram (
		.clk  (clk),
		.we   (ol_we),
		.waddr(ol_waddr),
		.wdata(ol_wdata),
		.raddr(tgt_d),
		.rdata(ol_rdata)
	);

endmodule

`default_nettype wire

@@ hw/rtl/lru_frame_replacer.sv @@
`default_nettype none

// LRU replacer for buffer frames: keeps the evictable frames as a doubly linked
// list in two link memories (one read and one write port each, registered read)
// with a presence bit per frame and head, tail and count registers. Commands
// arrive on s_* (victim, pin, unpin) and each gives exactly one result on m_*
// carrying found, the victim frame and the count afterwards. An operation that
// unlinks or inserts one frame reads the registered link memories and then
// writes back the neighbouring links; an unpin that first drops the oldest
// frame unlinks it before the insert. The result sits in an output register,
// so a new command is taken while it waits. The capacity is written on cfg_*;
// the user must do so only while no command is in flight, as the block
// does not enforce it; 0 counts as 1.
module lru_frame_replacer #(
	parameter int FRAMES = 64
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire  [7:0]                 s_tdata,   // frame[5:0], zero[7:6]
	input  wire  [lfr_pkg::CMD_W-1:0]  s_tuser,   // cmd[1:0]
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [15:0]                m_tdata,   // victim_frame[5:0], size[12:6], zero[15:13]
	output logic                       m_tuser,   // found[0]
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [lfr_pkg::CAP_W-1:0]  cfg_data
);

	logic [lfr_pkg::CAP_W-1:0] cap_q;
	lfr_pkg::req_t             req;
	lfr_pkg::res_t             res, res_q;
	logic                      res_valid, res_ready;
	logic                      m_tvalid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfr_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	assign req.cmd   = lfr_pkg::cmd_t'(s_tuser);
	assign req.frame = s_tdata[lfr_pkg::FID_W-1:0];

	lfr_seq #(
		.FRAMES(FRAMES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.req      (req),
		.cap      (cap_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register frees the sequencer as soon as a transaction is handed over
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.found;
	assign m_tdata  = {3'b000, res_q.size, res_q.victim_frame};

endmodule

`default_nettype wire
